[rtl/core/gaq_pkg.sv]
// ============================================================================
// gaq_pkg
// Shared types and constants for the group absmax int8 quantizer.
// ============================================================================
package gaq_pkg;

    // Default number of samples in a full group.
    localparam int GROUP_LEN_DEF = 32;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int QV_W     = 8;
    localparam int SCALE_W  = 25;
    localparam int MAG_W    = 16;

    // Serial divider geometry.
    localparam int DIV_W    = MAG_W + 1;
    localparam int SHIFT_W  = SCALE_W;
    localparam int STEP_W   = 5;
    localparam int NUM_W    = 24;

    // The scale is floor((m * 2^17 + 127) / 254): 25 quotient bits.
    localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(25);
    localparam logic [DIV_W-1:0]  SCALE_DIVISOR = DIV_W'(254);
    localparam logic [16:0]       SCALE_LOW = 17'd127;

    // A value is floor((254 * |x| + m) / (2 * m)): at most 127, 7 bits.
    localparam logic [STEP_W-1:0] VALUE_STEPS = STEP_W'(7);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'b1;

    // Result kinds.
    localparam logic KIND_SCALE = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_READ,
        ST_LOAD,
        ST_DIV
    } gaq_state_t;

endpackage

[rtl/core/gaq_ram.sv]
// ============================================================================
// gaq_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module gaq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/gaq_div.sv]
// ============================================================================
// gaq_div
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module gaq_div
    import gaq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   rem_init,
    input  logic [SHIFT_W-1:0] bits_init,
    input  logic [DIV_W-1:0]   divisor,
    input  logic [STEP_W-1:0]  steps,
    output logic               busy,
    output logic [SHIFT_W-1:0] quotient
);

    logic [STEP_W-1:0]  count_reg;
    logic [STEP_W-1:0]  count_next;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   rem_next;
    logic [SHIFT_W-1:0] bits_reg;
    logic [SHIFT_W-1:0] bits_next;
    logic [SHIFT_W-1:0] quot_reg;
    logic [SHIFT_W-1:0] quot_next;
    logic [DIV_W-1:0]   divisor_reg;
    logic [DIV_W-1:0]   divisor_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W+1:0]   diff;
    logic               qbit;

    // The caller preloads a remainder below the divisor, so one subtract
    // per step is enough.
    assign trial = {rem_reg, bits_reg[SHIFT_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor_reg};
    assign qbit  = ~diff[DIV_W+1];

    always_comb
    begin
        count_next   = count_reg;
        rem_next     = rem_reg;
        bits_next    = bits_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            count_next   = steps;
            rem_next     = rem_init;
            bits_next    = bits_init;
            quot_next    = '0;
            divisor_next = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - STEP_W'(1);
            rem_next   = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            bits_next  = {bits_reg[SHIFT_W-2:0], 1'b0};
            quot_next  = {quot_reg[SHIFT_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        bits_reg    <= bits_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quot_reg;

endmodule

[rtl/core/group_absmax_int8_quantizer_unit.sv]
// ============================================================================
// group_absmax_int8_quantizer_unit
// Groupwise absmax int8 quantizer: buffers a group of samples, then emits
// the group scale and one int8 value per sample.
// ============================================================================
//
//  Channel  Signals                                   Direction  Beat
//  input    in_valid, in_stall, sample                in         one sample
//  output   out_valid, out_stall, kind, int8_value,   out        one result
//           scale, last_of_group, last_of_tensor
//  config   cfg_we, cfg_index, cfg_data               in         one register
//
//  A sample that does not close its group is only buffered; input stays open.
//  A closing sample starts the scale: 25 divider steps, then a hand-off to
//  the output register. Each value then passes through a buffer read, a
//  divider load, 7 divider steps and a hand-off; the serial divider paces it.
//  Input is stalled from a group's close until its last value is handed off.
//  A stalled output holds its beat; the divider waits for the slot to free.
//  Reset clears all counters and positions; config registers reset to 1.
//
module group_absmax_int8_quantizer_unit
    import gaq_pkg::*;
#(
    parameter int GROUP_LEN = GROUP_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       kind,
    output logic signed [QV_W-1:0]     int8_value,
    output logic [SCALE_W-1:0]         scale,
    output logic                       last_of_group,
    output logic                       last_of_tensor,

    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int FILL_W = $clog2(GROUP_LEN + 1);
    localparam int ADDR_W = $clog2(GROUP_LEN);

    gaq_state_t state_reg;
    gaq_state_t state_next;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [MAG_W-1:0]  max_reg;
    logic [MAG_W-1:0]  max_next;
    logic [CFG_W-1:0]  col_reg;
    logic [CFG_W-1:0]  col_next;
    logic [CFG_W-1:0]  row_reg;
    logic [CFG_W-1:0]  row_next;
    logic [CFG_W-1:0]  row_length_reg;
    logic [CFG_W-1:0]  row_length_next;
    logic [CFG_W-1:0]  row_count_reg;
    logic [CFG_W-1:0]  row_count_next;
    logic [FILL_W-1:0] count_reg;
    logic [FILL_W-1:0] count_next;
    logic [FILL_W-1:0] idx_reg;
    logic [FILL_W-1:0] idx_next;
    logic              tensor_end_reg;
    logic              tensor_end_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [MAG_W-1:0]  m_reg;
    logic [MAG_W-1:0]  m_next;
    logic              neg_reg;
    logic              neg_next;
    logic              out_kind_reg;
    logic              out_kind_next;
    logic [QV_W-1:0]   out_qv_reg;
    logic [QV_W-1:0]   out_qv_next;
    logic [SCALE_W-1:0] out_scale_reg;
    logic [SCALE_W-1:0] out_scale_next;
    logic              out_log_reg;
    logic              out_log_next;
    logic              out_lot_reg;
    logic              out_lot_next;

    logic              accept;
    logic              out_free;
    logic [MAG_W-1:0]  sample_mag;
    logic [MAG_W-1:0]  new_max;
    logic [MAG_W-1:0]  new_m;
    logic [FILL_W-1:0] fill_inc;
    logic [CFG_W:0]    eff_length;
    logic [CFG_W:0]    eff_count;
    logic              row_end;
    logic              tensor_end;
    logic              group_end;
    logic              last_value;

    logic                ram_rd_en;
    logic [SAMPLE_W-1:0] ram_rd_data;
    logic [MAG_W-1:0]    rd_mag;
    logic [NUM_W-1:0]    value_num;
    logic [QV_W-1:0]     qmag;

    logic               div_start;
    logic [DIV_W-1:0]   div_rem_init;
    logic [SHIFT_W-1:0] div_bits_init;
    logic [DIV_W-1:0]   div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic               div_busy;
    logic [SHIFT_W-1:0] div_quotient;

    // ------------------------------------------------------------------
    // Input side: magnitude, running max and row bookkeeping.
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // The most negative sample maps to 0x8000, which is its true magnitude.
    assign sample_mag = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
    assign new_max    = (sample_mag > max_reg) ? sample_mag : max_reg;
    assign new_m      = (new_max == '0) ? MAG_W'(1) : new_max;
    assign fill_inc   = fill_reg + FILL_W'(1);

    // A zero register counts as 65536.
    assign eff_length = {(row_length_reg == '0), row_length_reg};
    assign eff_count  = {(row_count_reg == '0), row_count_reg};
    assign row_end    = ({1'b0, col_reg} + (CFG_W+1)'(1)) >= eff_length;
    assign tensor_end = row_end && (({1'b0, row_reg} + (CFG_W+1)'(1)) >= eff_count);
    assign group_end  = row_end || (fill_inc >= FILL_W'(GROUP_LEN));

    // ------------------------------------------------------------------
    // Output side: dividend for one value from the buffered sample.
    // ------------------------------------------------------------------
    assign rd_mag    = ram_rd_data[SAMPLE_W-1] ? MAG_W'(~ram_rd_data + 1'b1)
                                               : MAG_W'(ram_rd_data);
    // 254 * |x| + m; it stays below 128 * (2 * m), so seven steps suffice.
    assign value_num = {rd_mag, 8'b0} - {7'b0, rd_mag, 1'b0} + {8'b0, m_reg};
    assign qmag      = {1'b0, div_quotient[QV_W-2:0]};
    assign last_value = ((idx_reg + FILL_W'(1)) == count_reg);

    gaq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (GROUP_LEN)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (sample),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    gaq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .quotient  (div_quotient)
    );

    // ------------------------------------------------------------------
    // Sequencer and datapath next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        max_next        = max_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        row_length_next = row_length_reg;
        row_count_next  = row_count_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        tensor_end_next = tensor_end_reg;
        out_valid_next  = out_valid_reg && out_stall;
        m_next          = m_reg;
        neg_next        = neg_reg;
        out_kind_next   = out_kind_reg;
        out_qv_next     = out_qv_reg;
        out_scale_next  = out_scale_reg;
        out_log_next    = out_log_reg;
        out_lot_next    = out_lot_reg;
        ram_rd_en       = 1'b0;
        div_start       = 1'b0;
        div_rem_init    = value_num[NUM_W-1:7];
        div_bits_init   = {value_num[6:0], (SHIFT_W-7)'(0)};
        div_divisor     = {m_reg, 1'b0};
        div_steps       = VALUE_STEPS;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_LENGTH: row_length_next = cfg_data;
                REG_ROW_COUNT:  row_count_next  = cfg_data;
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next = row_end ? '0 : col_reg + CFG_W'(1);
                    if (row_end)
                    begin
                        row_next = tensor_end ? '0 : row_reg + CFG_W'(1);
                    end
                    if (group_end)
                    begin
                        fill_next       = '0;
                        max_next        = '0;
                        count_next      = fill_inc;
                        tensor_end_next = tensor_end;
                        m_next          = new_m;
                        // Dividend m * 2^17 + 127, split so the first
                        // remainder is already below 254.
                        div_start     = 1'b1;
                        div_rem_init  = DIV_W'(new_m[MAG_W-1:8]);
                        div_bits_init = {new_m[7:0], SCALE_LOW};
                        div_divisor   = SCALE_DIVISOR;
                        div_steps     = SCALE_STEPS;
                        state_next    = ST_SCALE;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                        max_next  = new_max;
                    end
                end
            end

            ST_SCALE:
            begin
                if (!div_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SCALE;
                    out_qv_next    = '0;
                    out_scale_next = div_quotient[SCALE_W-1:0];
                    out_log_next   = 1'b0;
                    out_lot_next   = 1'b0;
                    idx_next       = '0;
                    state_next     = ST_READ;
                end
            end

            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                div_start  = 1'b1;
                neg_next   = ram_rd_data[SAMPLE_W-1];
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_VALUE;
                    out_qv_next    = neg_reg ? QV_W'(-qmag) : qmag;
                    out_scale_next = '0;
                    out_log_next   = last_value;
                    out_lot_next   = last_value && tensor_end_reg;
                    if (last_value)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + FILL_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            max_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            row_length_reg <= CFG_W'(1);
            row_count_reg  <= CFG_W'(1);
            count_reg      <= '0;
            idx_reg        <= '0;
            tensor_end_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            max_reg        <= max_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            row_length_reg <= row_length_next;
            row_count_reg  <= row_count_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            tensor_end_reg <= tensor_end_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        neg_reg       <= neg_next;
        out_kind_reg  <= out_kind_next;
        out_qv_reg    <= out_qv_next;
        out_scale_reg <= out_scale_next;
        out_log_reg   <= out_log_next;
        out_lot_reg   <= out_lot_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign int8_value     = out_qv_reg;
    assign scale          = out_scale_reg;
    assign last_of_group  = out_log_reg;
    assign last_of_tensor = out_lot_reg;

endmodule
